// File: rtl/core/led_matrix_pixel_buffer_serializer_unit_macros.svh
// Assertion macros for the checker of the pixel buffer serialiser.
`ifndef LED_MATRIX_PIXEL_BUFFER_SERIALIZER_UNIT_MACROS_SVH
`define LED_MATRIX_PIXEL_BUFFER_SERIALIZER_UNIT_MACROS_SVH

// A property checked on every rising clock edge outside reset.
`define LMPBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lmpbs check failed");

// A condition that must never be seen outside reset.
`define LMPBS_ASSERT_NEVER(lbl, cond) `LMPBS_ASSERT(lbl, !(cond))

`endif

// File: rtl/core/lmpbs_pkg.sv
`default_nettype none

package lmpbs_pkg;

  // Geometry of the display row and of the pixel store.
  localparam int NUM_DISPLAYS = 4;
  localparam int NUM_SLOTS    = 4;
  localparam int DISP_COLS    = 8;
  localparam int DISP_W       = 2;
  localparam int COL_W        = 3;
  localparam int PIX_W        = 8;

  // Payload widths.
  localparam int COLUMN_W   = 5;
  localparam int ROW_W      = 3;
  localparam int REG_ADDR_W = 4;
  localparam int REG_DATA_W = 8;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_DISPLAY_ORDER     = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_DISPLAY_ROTATIONS = 3'd4;
  localparam logic [7:0] DISPLAY_ORDER_RESET     = 8'd228;
  localparam logic [7:0] DISPLAY_ROTATIONS_RESET = 8'd0;

  // Driver registers that carry one row of pixels.
  localparam logic [REG_ADDR_W-1:0] DIGIT_FIRST = 4'd1;
  localparam logic [REG_ADDR_W-1:0] DIGIT_LAST  = 4'd8;

  // Frame counter of one transfer.
  localparam int FRAME_CNT_W = 2;
  localparam logic [FRAME_CNT_W-1:0] FRAME_LAST_IDX = 2'd3;

  // Rotation of one physical display.
  typedef enum logic [1:0] {
    ROT_NONE  = 2'd0,
    ROT_CW90  = 2'd1,
    ROT_180   = 2'd2,
    ROT_CCW90 = 2'd3
  } rot_e;

endpackage

`default_nettype wire

// File: rtl/core/led_matrix_pixel_buffer_serializer_unit.sv
// Pixel buffer and frame serialiser for a row of four cascaded 8x8 LED matrix drivers.
// Input channel (in_valid_i/in_ready_o): one request is either a pixel write
// (func_i = 0) or a register transfer (func_i = 1).
// Output channel (out_valid_o/out_ready_i): a transfer yields four frames, the
// farthest device first, with frame_last_o high on the fourth.
// A pixel write completes in the cycle it is accepted and produces no frames.
// A transfer samples the store when accepted; its first frame is offered in the
// next cycle and one frame leaves per cycle while the receiver is ready.
// Throughput: one pixel write per cycle while no transfer is pending; a transfer holds
// the output register until its last frame leaves, and the next request is taken then.
// A receiver stall holds the current frame and blocks new requests until the
// group has drained; writes to the store after a transfer do not alter its frames.
// Reset clears the pixel store, the busy flag and the frame counter (not the frame
// shift register) and loads the reset values of display_order and display_rotations;
// no clearing pass is needed. The APB port writes display_order at 0x0 and display_rotations at 0x4.
`default_nettype none

module led_matrix_pixel_buffer_serializer_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lmpbs_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [lmpbs_pkg::PDATA_W-1:0]      pwdata,
  output logic      [lmpbs_pkg::PDATA_W-1:0]      prdata,
  output logic                                    pready,
  // Request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               func_i,
  input  wire logic [lmpbs_pkg::COLUMN_W-1:0]     column_i,
  input  wire logic [lmpbs_pkg::ROW_W-1:0]        row_i,
  input  wire logic                               pixel_on_i,
  input  wire logic [lmpbs_pkg::REG_ADDR_W-1:0]   reg_addr_i,
  input  wire logic [lmpbs_pkg::REG_DATA_W-1:0]   reg_data_i,
  // Frame channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [lmpbs_pkg::REG_ADDR_W-1:0]   frame_addr_o,
  output logic      [lmpbs_pkg::REG_DATA_W-1:0]   frame_data_o,
  output logic                                    frame_last_o
);

  import lmpbs_pkg::*;

  localparam int FRAMES_W = NUM_SLOTS * PIX_W;

  logic [7:0] order_q;
  logic [7:0] rot_cfg_q;
  logic       cfg_we;

  logic [PIX_W-1:0] pix_q [NUM_SLOTS][DISP_COLS];

  logic                   in_fire;
  logic                   out_fire;
  logic                   pix_we;
  logic [1:0]             slot;
  logic [DISP_W-1:0]      disp;
  rot_e                   rot;
  logic [COL_W-1:0]       x_mir;
  logic [COL_W-1:0]       y_mir;
  logic [COL_W-1:0]       x_st;
  logic [COL_W-1:0]       y_st;

  logic                   is_digit;
  logic [COL_W-1:0]       digit_col;
  logic [FRAMES_W-1:0]    frames_d;

  logic                   busy_q;
  logic                   busy_d;
  logic [FRAME_CNT_W-1:0] cnt_q;
  logic [FRAME_CNT_W-1:0] cnt_d;
  logic [FRAMES_W-1:0]    frames_q;
  logic [REG_ADDR_W-1:0]  addr_q;

  // Configuration registers; a write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= DISPLAY_ORDER_RESET;
      rot_cfg_q <= DISPLAY_ROTATIONS_RESET;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        rot_cfg_q <= pwdata[7:0];
      end else begin
        order_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_DISPLAY_ORDER:     prdata = {24'd0, order_q};
      ADDR_DISPLAY_ROTATIONS: prdata = {24'd0, rot_cfg_q};
      default:                prdata = '0;
    endcase
  end

  // Handshakes.
  assign in_ready_o = !busy_q || (out_ready_i && cnt_q == FRAME_LAST_IDX);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  // Pixel mapping: slot to display, then mirror and swap by the display's rotation.
  always_comb begin
    slot  = column_i[COLUMN_W-1:COL_W];
    disp  = order_q[2*slot +: DISP_W];
    rot   = rot_e'(rot_cfg_q[2*disp +: 2]);
    x_mir = (rot == ROT_180 || rot == ROT_CCW90) ? ~column_i[COL_W-1:0]
                                                 : column_i[COL_W-1:0];
    y_mir = (rot == ROT_CW90 || rot == ROT_180) ? ~row_i : row_i;
    if (rot == ROT_CW90 || rot == ROT_CCW90) begin
      x_st = y_mir;
      y_st = x_mir;
    end else begin
      x_st = x_mir;
      y_st = y_mir;
    end
    pix_we = in_fire && !func_i && (int'(disp) < NUM_DISPLAYS);
  end

  // Pixel store: one byte per column, a bit per row, written one bit at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_SLOTS; b++) begin
        for (int c = 0; c < DISP_COLS; c++) begin
          pix_q[b][c] <= '0;
        end
      end
    end else if (pix_we) begin
      pix_q[disp][x_st][y_st] <= pixel_on_i;
    end
  end

  // Frame data of a transfer: the same column of each display, or reg_data repeated.
  always_comb begin
    is_digit  = (reg_addr_i >= DIGIT_FIRST) && (reg_addr_i <= DIGIT_LAST);
    digit_col = reg_addr_i[COL_W-1:0] - COL_W'(1);
    if (is_digit) begin
      for (int b = 0; b < NUM_SLOTS; b++) begin
        frames_d[b*PIX_W +: PIX_W] = pix_q[b][digit_col];
      end
    end else begin
      frames_d = {NUM_SLOTS{reg_data_i}};
    end
  end

  // Frame counter and busy flag of the output register.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (out_fire) begin
      cnt_d = cnt_q + FRAME_CNT_W'(1);
      if (cnt_q == FRAME_LAST_IDX) begin
        busy_d = 1'b0;
      end
    end
    if (in_fire && func_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Frame shift register: the farthest display sits in the top byte.
  always_ff @(posedge clk_i) begin
    if (in_fire && func_i) begin
      frames_q <= frames_d;
      addr_q   <= reg_addr_i;
    end else if (out_fire) begin
      frames_q <= {frames_q[FRAMES_W-PIX_W-1:0], {PIX_W{1'b0}}};
    end
  end

  assign out_valid_o  = busy_q;
  assign frame_addr_o = addr_q;
  assign frame_data_o = frames_q[FRAMES_W-1 -: PIX_W];
  assign frame_last_o = (cnt_q == FRAME_LAST_IDX);

endmodule

`default_nettype wire

// File: rtl/core/lmpbs_checker.sv
`default_nettype none
`include "led_matrix_pixel_buffer_serializer_unit_macros.svh"

module lmpbs_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               func_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [lmpbs_pkg::REG_ADDR_W-1:0]   frame_addr_o,
  input wire logic                               frame_last_o
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // A stalled frame is still offered in the next cycle.
  `LMPBS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // An accepted transfer offers its first frame in the next cycle.
  `LMPBS_ASSERT(a_xfer_starts, in_fire && func_i |=> out_valid_o && !frame_last_o)

  // No new request is taken while a frame group is still in its middle.
  `LMPBS_ASSERT_NEVER(a_no_accept_mid_group, out_valid_o && !frame_last_o && in_ready_o)

  // All frames of one group carry the same register address.
  `LMPBS_ASSERT(a_addr_steady,
    out_fire && !frame_last_o |=> out_valid_o && frame_addr_o == $past(frame_addr_o))

  // A pixel write on an idle output produces no frame.
  `LMPBS_ASSERT(a_write_silent, in_fire && !func_i && !out_valid_o |=> !out_valid_o)

endmodule

bind led_matrix_pixel_buffer_serializer_unit lmpbs_checker u_lmpbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .func_i       (func_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_addr_o (frame_addr_o),
  .frame_last_o (frame_last_o)
);

`default_nettype wire
